// File: rtl/modular_square_root_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the modular square root block
// Shared concurrent assertion forms.
// ----------------------------------------------------------------------------
`ifndef MODULAR_SQUARE_ROOT_MACROS_SVH
`define MODULAR_SQUARE_ROOT_MACROS_SVH

// implication checked every cycle out of reset
`define MSR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define MSR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/msr_pkg.sv
// ----------------------------------------------------------------------------
// msr_pkg
// Types and constants for the modular square root block.
// ----------------------------------------------------------------------------
package msr_pkg;

  localparam int unsigned FieldWidth    = 32;
  localparam int unsigned NrSearchLimit = 1024;

  typedef struct packed {
    logic start;
  } msr_mul_ctl_t;

endpackage

// File: rtl/msr_mulmod.sv
// ----------------------------------------------------------------------------
// msr_mulmod
// Bit-serial modular multiplier: one bit of b per cycle, double-and-add.
// ----------------------------------------------------------------------------
module msr_mulmod import msr_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  msr_mul_ctl_t ctl_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] m_i,
  output logic         done_o,
  output logic [W-1:0] p_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  acc_q, acc_d, b_q, b_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          run_q, run_d, done_q, done_d;
  logic [W:0]    dbl, dbl_r, add, add_r;

  always_comb begin
    dbl   = {acc_q, 1'b0};
    dbl_r = (dbl >= {1'b0, m_i}) ? dbl - {1'b0, m_i} : dbl;
    add   = dbl_r + {1'b0, a_i};
    add_r = (add >= {1'b0, m_i}) ? add - {1'b0, m_i} : add;
    acc_d  = acc_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (ctl_i.start) begin
      acc_d = '0;
      b_d   = b_i;
      cnt_d = CW'(W);
      run_d = 1'b1;
    end else if (run_q) begin
      acc_d = b_q[W-1] ? add_r[W-1:0] : dbl_r[W-1:0];
      b_d   = {b_q[W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

// File: rtl/modular_square_root.sv
// ----------------------------------------------------------------------------
// modular_square_root
// Tonelli-Shanks modular square root over one bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// channel  dir  handshake               payload
// in       in   in_valid_i / in_stall_o  residue_i, modulus_i
// out      out  out_valid_o / out_stall_i root_o, no_root_o
// One item at a time. Each modular multiply runs bit-serially in the
// shared multiplier; an item costs a few hundred multiplies (exponentiations,
// non-residue search, squaring loop). The reduction n mod p runs bit-serially.
// Reset clears all control; the result register holds while out_stall_i.
// ----------------------------------------------------------------------------
module modular_square_root import msr_pkg::*; #(
  parameter int unsigned MOD_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [FieldWidth-1:0] residue_i,
  input  logic [FieldWidth-1:0] modulus_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [FieldWidth-1:0] root_o,
  output logic                  no_root_o
);

`include "modular_square_root_macros.svh"

  localparam int unsigned W  = MOD_WIDTH;
  localparam int unsigned EW = W + 1;
  localparam int unsigned CW = $clog2(W + 2);
  localparam int unsigned SW = $clog2(W + 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RED   = 5'd1;
  localparam logic [4:0] S_DISP  = 5'd2;
  localparam logic [4:0] S_PINIT = 5'd3;
  localparam logic [4:0] S_PSTEP = 5'd4;
  localparam logic [4:0] S_PMUL  = 5'd5;
  localparam logic [4:0] S_PSQ   = 5'd6;
  localparam logic [4:0] S_EULER = 5'd7;
  localparam logic [4:0] S_FACT  = 5'd8;
  localparam logic [4:0] S_ZTEST = 5'd9;
  localparam logic [4:0] S_CPOW  = 5'd10;
  localparam logic [4:0] S_TPOW  = 5'd11;
  localparam logic [4:0] S_RPOW  = 5'd12;
  localparam logic [4:0] S_LOOP  = 5'd13;
  localparam logic [4:0] S_SQ    = 5'd14;
  localparam logic [4:0] S_BSQ   = 5'd15;
  localparam logic [4:0] S_CUPD  = 5'd16;
  localparam logic [4:0] S_TUPD  = 5'd17;
  localparam logic [4:0] S_RUPD  = 5'd18;
  localparam logic [4:0] S_CHK   = 5'd19;
  localparam logic [4:0] S_OUT   = 5'd20;
  localparam logic [4:0] S_Q3    = 5'd21;

  // return points of the shared power routine
  localparam logic [2:0] R_EULER = 3'd0;
  localparam logic [2:0] R_ZTEST = 3'd1;
  localparam logic [2:0] R_CPOW  = 3'd2;
  localparam logic [2:0] R_TPOW  = 3'd3;
  localparam logic [2:0] R_RPOW  = 3'd4;
  localparam logic [2:0] R_Q3    = 3'd5;

  logic [4:0]    st_q, st_d;
  logic [2:0]    ret_q, ret_d;
  logic [W-1:0]  n_q, n_d, p_q, p_d, nraw_q, nraw_d;
  logic [W-1:0]  q_q, q_d, z_q, z_d, c_q, c_d, t_q, t_d, r_q, r_d, b_q, b_d;
  logic [W-1:0]  sq_q, sq_d, acc_q, acc_d, base_q, base_d;
  logic [EW-1:0] e_q, e_d;
  logic [SW-1:0] s_q, s_d, m_q, m_d, i_q, i_d, j_q, j_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  rem_q, rem_d;
  logic          vld_q, vld_d, fail_q, fail_d;
  logic [FieldWidth-1:0] root_q, root_d;
  logic [FieldWidth-1:0] out_root_q, out_root_d;
  logic          out_fail_q, out_fail_d;

  msr_mul_ctl_t  mctl;
  logic [W-1:0]  ma, mb, mp;
  logic          mdone;

  msr_mulmod #(.W(W)) u_mul (
    .clk_i (clk_i), .rst_ni(rst_ni), .ctl_i(mctl),
    .a_i   (ma), .b_i(mb), .m_i(p_q), .done_o(mdone), .p_o(mp)
  );

  logic [W:0]   rsh;
  logic [W-1:0] half, pm1;
  logic         mbusy_q, mbusy_d;

  assign pm1  = p_q - 1'b1;
  assign half = pm1 >> 1;

  always_comb begin
    st_d = st_q; ret_d = ret_q; n_d = n_q; p_d = p_q; nraw_d = nraw_q;
    q_d = q_q; z_d = z_q; c_d = c_q; t_d = t_q; r_d = r_q; b_d = b_q;
    sq_d = sq_q; acc_d = acc_q; base_d = base_q; e_d = e_q;
    s_d = s_q; m_d = m_q; i_d = i_q; j_d = j_q; cnt_d = cnt_q; rem_d = rem_q;
    vld_d = vld_q; fail_d = fail_q; root_d = root_q; mbusy_d = mbusy_q;
    out_root_d = out_root_q; out_fail_d = out_fail_q;
    mctl = '0; ma = '0; mb = '0;
    rsh = {rem_q, nraw_q[W-1]};
    if (vld_q && !out_stall_i) vld_d = 1'b0;

    unique case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          nraw_d = W'(residue_i);
          p_d    = W'(modulus_i);
          rem_d  = '0;
          cnt_d  = CW'(W);
          fail_d = 1'b0;
          root_d = '0;
          st_d   = S_RED;
        end
      end
      S_RED: begin
        // restoring reduction of n by p, one bit a cycle
        rem_d  = (rsh >= {1'b0, p_q}) ? W'(rsh - {1'b0, p_q}) : rsh[W-1:0];
        nraw_d = {nraw_q[W-2:0], 1'b0};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) st_d = S_DISP;
      end
      S_DISP: begin
        n_d = rem_q;
        if (p_q == '0) begin
          fail_d = 1'b1; st_d = S_OUT;
        end else if (p_q == W'(2)) begin
          root_d = FieldWidth'(rem_q[0]); st_d = S_OUT;
        end else if (rem_q == '0) begin
          st_d = S_OUT;
        end else begin
          base_d = rem_q; e_d = EW'(half); ret_d = R_EULER; st_d = S_PINIT;
        end
      end
      // shared power: acc = base^e mod p, LSB first
      S_PINIT: begin
        acc_d = W'(1); st_d = S_PSTEP;
      end
      S_PSTEP: begin
        if (e_q == '0) begin
          unique case (ret_q)
            R_EULER: st_d = S_EULER;
            R_ZTEST: st_d = S_ZTEST;
            R_CPOW:  st_d = S_CPOW;
            R_TPOW:  st_d = S_TPOW;
            R_RPOW:  st_d = S_RPOW;
            R_Q3:    st_d = S_Q3;
            default: st_d = S_OUT;
          endcase
        end else if (e_q[0]) begin
          st_d = S_PMUL;
        end else begin
          st_d = S_PSQ;
        end
      end
      S_PMUL: begin
        ma = acc_q; mb = base_q;
        if (!mbusy_q) begin
          mctl.start = 1'b1; mbusy_d = 1'b1;
        end else if (mdone) begin
          acc_d = mp; mbusy_d = 1'b0; st_d = S_PSQ;
        end
      end
      S_PSQ: begin
        ma = base_q; mb = base_q;
        if (!mbusy_q) begin
          mctl.start = 1'b1; mbusy_d = 1'b1;
        end else if (mdone) begin
          base_d = mp; mbusy_d = 1'b0; e_d = e_q >> 1; st_d = S_PSTEP;
        end
      end
      S_EULER: begin
        if (acc_q != W'(1)) begin
          fail_d = 1'b1; st_d = S_OUT;
        end else if (p_q[1:0] == 2'b11) begin
          base_d = n_q; e_d = EW'(p_q >> 2) + 1'b1; ret_d = R_Q3; st_d = S_PINIT;
        end else begin
          q_d = pm1; s_d = '0; st_d = S_FACT;
        end
      end
      S_FACT: begin
        if (!q_q[0]) begin
          q_d = q_q >> 1; s_d = s_q + 1'b1;
        end else begin
          z_d = W'(2);
          if (p_q <= W'(2)) begin
            fail_d = 1'b1; st_d = S_OUT;
          end else begin
            base_d = W'(2); e_d = EW'(half); ret_d = R_ZTEST; st_d = S_PINIT;
          end
        end
      end
      S_ZTEST: begin
        if (acc_q == pm1) begin
          base_d = z_q; e_d = EW'(q_q); ret_d = R_CPOW; st_d = S_PINIT;
        end else if ((EW'(z_q) + 1'b1 >= EW'(p_q)) ||
                     (EW'(z_q) + 1'b1 >= EW'(NrSearchLimit))) begin
          fail_d = 1'b1; st_d = S_OUT;
        end else begin
          z_d = z_q + 1'b1; base_d = z_q + 1'b1; e_d = EW'(half);
          st_d = S_PINIT;
        end
      end
      S_CPOW: begin
        c_d = acc_q; base_d = n_q; e_d = EW'(q_q); ret_d = R_TPOW; st_d = S_PINIT;
      end
      S_TPOW: begin
        t_d = acc_q; base_d = n_q; e_d = EW'(q_q >> 1) + 1'b1;
        ret_d = R_RPOW; st_d = S_PINIT;
      end
      S_RPOW: begin
        r_d = acc_q; m_d = s_q; st_d = S_LOOP;
      end
      S_LOOP: begin
        if (t_q == W'(1)) begin
          st_d = S_CHK;
        end else begin
          i_d = '0; sq_d = t_q; st_d = S_SQ;
        end
      end
      S_SQ: begin
        if (i_q >= m_q) begin
          fail_d = 1'b1; st_d = S_OUT;
        end else if (sq_q == W'(1)) begin
          b_d = c_q; j_d = '0; st_d = S_BSQ;
        end else begin
          ma = sq_q; mb = sq_q;
          if (!mbusy_q) begin
            mctl.start = 1'b1; mbusy_d = 1'b1;
          end else if (mdone) begin
            sq_d = mp; i_d = i_q + 1'b1; mbusy_d = 1'b0;
          end
        end
      end
      S_BSQ: begin
        if (32'(j_q) + 32'd1 >= 32'(m_q) - 32'(i_q)) begin
          m_d = i_q; st_d = S_CUPD;
        end else begin
          ma = b_q; mb = b_q;
          if (!mbusy_q) begin
            mctl.start = 1'b1; mbusy_d = 1'b1;
          end else if (mdone) begin
            b_d = mp; j_d = j_q + 1'b1; mbusy_d = 1'b0;
          end
        end
      end
      S_CUPD: begin
        ma = b_q; mb = b_q;
        if (!mbusy_q) begin
          mctl.start = 1'b1; mbusy_d = 1'b1;
        end else if (mdone) begin
          c_d = mp; mbusy_d = 1'b0; st_d = S_TUPD;
        end
      end
      S_TUPD: begin
        ma = t_q; mb = c_q;
        if (!mbusy_q) begin
          mctl.start = 1'b1; mbusy_d = 1'b1;
        end else if (mdone) begin
          t_d = mp; mbusy_d = 1'b0; st_d = S_RUPD;
        end
      end
      S_RUPD: begin
        ma = r_q; mb = b_q;
        if (!mbusy_q) begin
          mctl.start = 1'b1; mbusy_d = 1'b1;
        end else if (mdone) begin
          r_d = mp; mbusy_d = 1'b0; st_d = S_LOOP;
        end
      end
      S_Q3: begin
        r_d = acc_q; st_d = S_CHK;
      end
      S_CHK: begin
        ma = r_q; mb = r_q;
        if (!mbusy_q) begin
          mctl.start = 1'b1; mbusy_d = 1'b1;
        end else if (mdone) begin
          mbusy_d = 1'b0;
          if (mp == n_q) root_d = FieldWidth'(r_q);
          else fail_d = 1'b1;
          st_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!vld_q || !out_stall_i) begin
          vld_d      = 1'b1;
          out_root_d = fail_q ? '0 : root_q;
          out_fail_d = fail_q;
          st_d       = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      vld_q   <= 1'b0;
      mbusy_q <= 1'b0;
      cnt_q   <= '0;
      ret_q   <= R_EULER;
    end else begin
      st_q    <= st_d;
      vld_q   <= vld_d;
      mbusy_q <= mbusy_d;
      cnt_q   <= cnt_d;
      ret_q   <= ret_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; p_q <= p_d; nraw_q <= nraw_d; q_q <= q_d; z_q <= z_d;
    c_q <= c_d; t_q <= t_d; r_q <= r_d; b_q <= b_d; sq_q <= sq_d;
    acc_q <= acc_d; base_q <= base_d; e_q <= e_d; s_q <= s_d; m_q <= m_d;
    i_q <= i_d; j_q <= j_d; rem_q <= rem_d; fail_q <= fail_d; root_q <= root_d;
    out_root_q <= out_root_d; out_fail_q <= out_fail_d;
  end

  assign in_stall_o  = (st_q != S_IDLE);
  assign out_valid_o = vld_q;
  assign root_o      = out_root_q;
  assign no_root_o   = out_fail_q;

  `MSR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                  out_valid_o && $stable(root_o) && $stable(no_root_o))
  `MSR_ASSERT_IMP(a_fail_zero, clk_i, rst_ni, out_valid_o && no_root_o, root_o == '0)
  `MSR_ASSERT_IMP(a_mul_idle, clk_i, rst_ni, st_q == S_IDLE, !mbusy_q)

endmodule

// File: sim/tb_modular_square_root.sv
// ----------------------------------------------------------------------------
// tb_modular_square_root
// Drives residue/modulus pairs through the square root block under random
// idling on both channels and checks each root against a typed expectation
// or a Tonelli-Shanks predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb_modular_square_root;
  timeunit 1ns;
  timeprecision 1ps;
  import msr_pkg::*;

  typedef struct packed {
    logic [FieldWidth-1:0] root;
    logic                  no_root;
  } root_res_t;

  typedef struct {
    logic [FieldWidth-1:0] residue;
    logic [FieldWidth-1:0] modulus;
    bit                    typed;
    root_res_t             res;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [FieldWidth-1:0] residue_i = '0;
  logic [FieldWidth-1:0] modulus_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [FieldWidth-1:0] root_o;
  logic                  no_root_o;

  root_res_t   pending_roots[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned n_errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_roots = 0;
  int unsigned n_no_root = 0;

  modular_square_root u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2_000_000_000;
    $display("tb_modular_square_root failed");
    $finish;
  end

  function automatic longint unsigned mul_p(longint unsigned a, longint unsigned b,
                                           longint unsigned p);
    return (a * b) % p;
  endfunction

  function automatic longint unsigned pow_p(longint unsigned b, longint unsigned e,
                                           longint unsigned p);
    longint unsigned acc;
    acc = 1 % p;
    b = b % p;
    while (e != 0) begin
      if (e[0]) acc = mul_p(acc, b, p);
      b = mul_p(b, b, p);
      e = e >> 1;
    end
    return acc;
  endfunction

  // n in [1, p-1], p >= 3; returns 0 when no root is found
  function automatic bit solve_root(longint unsigned n, longint unsigned p,
                                    output longint unsigned r);
    longint unsigned half, q, z, c, t, b, sq;
    int unsigned s, m, i, j;
    bit found;
    half = (p - 1) / 2;
    r = 0;
    if (pow_p(n, half, p) != 1) return 0;
    if ((p & 3) == 3) begin
      r = pow_p(n, p / 4 + 1, p);
    end else begin
      q = p - 1;
      s = 0;
      found = 0;
      while (q[0] == 1'b0) begin
        q = q >> 1;
        s++;
      end
      for (z = 2; z < p && z < NrSearchLimit; z++) begin
        if (pow_p(z, half, p) == p - 1) begin
          found = 1;
          break;
        end
      end
      if (!found) return 0;
      c = pow_p(z, q, p);
      t = pow_p(n, q, p);
      r = pow_p(n, q / 2 + 1, p);
      m = s;
      while (t != 1) begin
        i = 0;
        sq = t;
        while (sq != 1) begin
          if (i >= m) return 0;
          sq = mul_p(sq, sq, p);
          i++;
        end
        if (i >= m) return 0;
        b = c;
        for (j = 0; j + 1 < m - i; j++) b = mul_p(b, b, p);
        m = i;
        c = mul_p(b, b, p);
        t = mul_p(t, c, p);
        r = mul_p(r, b, p);
      end
    end
    return mul_p(r, r, p) == n;
  endfunction

  function automatic root_res_t predict_root(logic [FieldWidth-1:0] residue,
                                             logic [FieldWidth-1:0] modulus);
    root_res_t res;
    longint unsigned n, p, r;
    n = 64'(residue);
    p = 64'(modulus);
    res = '0;
    if (p == 0) begin
      res.no_root = 1'b1;
    end else if (p == 2) begin
      res.root = FieldWidth'(n & 1);
    end else begin
      n = n % p;
      if (n != 0) begin
        if (solve_root(n, p, r)) res.root = r[FieldWidth-1:0];
        else res.no_root = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic bit is_prime(int unsigned v);
    if (v < 2) return 0;
    for (int unsigned d = 2; d * d <= v; d++) if (v % d == 0) return 0;
    return 1;
  endfunction

  task automatic send(logic [FieldWidth-1:0] residue, logic [FieldWidth-1:0] modulus,
                      bit typed, root_res_t typed_res);
    in_valid_i <= 1'b1;
    residue_i  <= residue;
    modulus_i  <= modulus;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_roots.push_back(typed ? typed_res : predict_root(residue, modulus));
    n_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    root_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_roots.size() == 0) begin
        $display("%0t: unexpected transfer root %0d no_root %0b", $time, root_o,
                 no_root_o);
        n_errors++;
      end else begin
        want = pending_roots.pop_front();
        if (want.root !== root_o) begin
          $display("%0t: root expected %0d actual %0d", $time, want.root, root_o);
          n_errors++;
        end
        if (want.no_root !== no_root_o) begin
          $display("%0t: no_root expected %0b actual %0b", $time, want.no_root,
                   no_root_o);
          n_errors++;
        end
        if (no_root_o) n_no_root++;
        else n_roots++;
      end
    end
  end

  stim_row_t stim_rows[] = '{
    '{32'd5, 32'd2, 1'b1, '{32'd1, 1'b0}},
    '{32'd4, 32'd2, 1'b1, '{32'd0, 1'b0}},
    '{32'd0, 32'd0, 1'b1, '{32'd0, 1'b1}},
    '{32'hFFFFFFFF, 32'd0, 1'b1, '{32'd0, 1'b1}},
    '{32'd123, 32'd1, 1'b1, '{32'd0, 1'b0}},
    '{32'd0, 32'd7, 1'b1, '{32'd0, 1'b0}},
    '{32'd14, 32'd7, 1'b1, '{32'd0, 1'b0}},
    '{32'd3, 32'd7, 1'b1, '{32'd0, 1'b1}},
    '{32'd2, 32'd3, 1'b1, '{32'd0, 1'b1}},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, '{32'd0, 1'b0}},
    '{32'd2, 32'd7, 1'b0, '0},
    '{32'd10, 32'd13, 1'b0, '0},
    '{32'd16, 32'd17, 1'b0, '0},
    '{32'hFFFFFFFF, 32'd4294967291, 1'b0, '0},
    '{32'h80000000, 32'd4294967279, 1'b0, '0},
    '{32'd1, 32'hFFFFFFFF, 1'b0, '0},
    '{32'd2, 32'd15, 1'b0, '0},
    '{32'd4, 32'd21, 1'b0, '0},
    '{32'd1, 32'd9, 1'b0, '0},
    '{32'd5, 32'd65537, 1'b0, '0},
    '{32'd3, 32'd998244353, 1'b0, '0},
    '{32'd5, 32'd3221225473, 1'b0, '0},
    '{32'd7, 32'd4293918721, 1'b0, '0},
    '{32'd2, 32'd2013265921, 1'b0, '0},
    '{32'd9, 32'd2147483647, 1'b0, '0}
  };

  logic [FieldWidth-1:0] big_primes[] = '{
    32'd4294967291, 32'd4294967279, 32'd2147483647, 32'd998244353,
    32'd3221225473, 32'd4293918721, 32'd2013265921, 32'd65537
  };

  initial begin
    longint unsigned p, n, x;
    int unsigned pick;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 13;
    recv_idle_pct = 83;
    foreach (stim_rows[k])
      send(stim_rows[k].residue, stim_rows[k].modulus, stim_rows[k].typed,
           stim_rows[k].res);

    // hold off until everything in flight has come back
    in_valid_i <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk_i);

    for (int k = 0; k < 300; k++) begin
      if (k == 100) begin
        send_idle_pct = 83;
        recv_idle_pct = 13;
      end else if (k == 200) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pick = $urandom_range(99);
      if (pick < 20) begin
        p = 64'(big_primes[$urandom_range(big_primes.size() - 1)]);
      end else if (pick < 90) begin
        p = 64'($urandom_range(3, 4095));
        if (pick < 80) while (!is_prime(32'(p))) p++;
      end else begin
        p = 64'($urandom_range(0, 2));
      end
      if (p > 2 && $urandom_range(99) < 60) begin
        x = 64'($urandom());
        n = mul_p(x % p, x % p, p);
        n = n + p * 64'($urandom_range(0, 32'((64'hFFFFFFFF - n) / p)));
      end else begin
        n = 64'($urandom());
      end
      send(n[FieldWidth-1:0], p[FieldWidth-1:0], 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (pending_roots.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Sent %0d residue/modulus pairs: %0d roots and %0d without a root.",
             n_sent, n_roots, n_no_root);
    if (n_errors == 0 && pending_roots.size() == 0) begin
      $display("tb_modular_square_root passed");
    end else begin
      $display("tb_modular_square_root failed");
    end
    $finish;
  end

endmodule
